[rtl/ipid_pkg.sv]
package ipid_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned ERR_W      = 25;
  localparam int unsigned DIFF_W     = 27;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PROD_W     = DIFF_W + GAIN_W;
  localparam int unsigned DIVIDEND_W = 44;
  localparam int unsigned REM_W      = GAIN_W + 1;
  localparam int unsigned ACC_W      = 46;
  localparam int unsigned DRIVE_W    = 32;

  // Divider: four quotient bits per cycle
  localparam int unsigned DIV_BITS_PER_STEP = 4;
  localparam int unsigned DIV_STEPS         = DIVIDEND_W / DIV_BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W         = $clog2(DIV_STEPS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_P_MUL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_DIV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_I_MUL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_I_DIV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_MUL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D_DIV   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd7;

  // Request kinds
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Divider control and status
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [GAIN_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/ipid_chan_if.sv]
interface ipid_req_if import ipid_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [SAMPLE_W-1:0] target;
  logic signed [SAMPLE_W-1:0] measured;

  modport source (output valid, output req_type, output target, output measured,
                  input ready);
  modport sink   (input valid, input req_type, input target, input measured,
                  output ready);
endinterface

interface ipid_rsp_if import ipid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_delta;
  logic                      clamped;

  modport source (output valid, output drive_delta, output clamped, input ready);
  modport sink   (input valid, input drive_delta, input clamped, output ready);
endinterface

[rtl/ipid_div.sv]
module ipid_div import ipid_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  count_r;
  logic [REM_W-1:0]      rem_r;
  logic [REM_W-1:0]      rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVIDEND_W-1:0] quo_nxt;
  logic [GAIN_W-1:0]     divisor_r;

  // Restoring division, several quotient bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      rem_nxt = {rem_nxt[REM_W-2:0], quo_nxt[DIVIDEND_W-1]};
      quo_nxt = {quo_nxt[DIVIDEND_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, divisor_r}) begin
        rem_nxt    = rem_nxt - {1'b0, divisor_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        count_r <= '0;
      end else if (busy_r) begin
        count_r <= count_r + 1'b1;
        if (count_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= '0;
      quo_r     <= req.dividend;
      divisor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[rtl/incremental_pid_step.sv]
// Incremental PID step.
// in_req carries requests: req_type 0 is an update with target and measured,
// req_type 1 clears the error history and gives no response. out_rsp carries
// one response per update: the drive change and a clamped flag. Both channels
// move a request on a clock edge where valid and ready are high.
// Gains and output limits are written through cfg_we/cfg_index/cfg_wdata;
// the user must do so only while no update is in flight; the block has no check.
// An update holds in_req.ready low from acceptance until its response is
// registered: for each of the three gain terms ST_MUL multiplies, ST_START
// loads the shared divider and ST_DIV waits for it (eleven steps of four
// quotient bits over a 44-bit dividend) and adds the quotient; then ST_DONE
// clamps and registers the response. The response shows on out_rsp once
// registered, and a new update is taken only after the last one is through.
// A clear is taken in ST_IDLE and in_req stays ready.
// The response sits in an output register, so a stalled receiver holds it
// while the next update is accepted and computed; the block then waits with
// the new result until the old one is taken.
// Synchronous reset (rst_n low) zeroes the history, empties the output
// register and sets gains to 0/1 and limits to the full 32-bit range.
module incremental_pid_step import ipid_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ipid_req_if.sink              in_req,
  ipid_rsp_if.source            out_rsp
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                    state_r;
  logic [1:0]                term_r;
  logic [GAIN_W-1:0]         p_mul_r, p_div_r, i_mul_r, i_div_r, d_mul_r, d_div_r;
  logic signed [DRIVE_W-1:0] floor_r, ceiling_r;
  logic signed [ERR_W-1:0]   e1_r, e2_r;
  logic signed [DIFF_W-1:0]  e_r, dp_r, d2_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      neg_r;
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic                      clamped_r;

  logic                      in_fire;
  logic                      out_free;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  err_x;
  logic signed [DIFF_W-1:0]  num;
  logic [DIFF_W-1:0]         mag;
  logic [GAIN_W-1:0]         gain_mul;
  logic [GAIN_W-1:0]         gain_div;
  logic [GAIN_W-1:0]         div_eff;
  logic signed [ACC_W-1:0]   quo_ext;
  logic signed [ACC_W-1:0]   lo_ext, hi_ext, t_lo, t_hi;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // Error and differences against the history
  assign err   = ERR_W'(in_req.target) - ERR_W'(in_req.measured);
  assign err_x = DIFF_W'(err);

  // Select the operands of the current term
  always_comb begin
    case (term_r)
      2'd0:    begin num = dp_r; gain_mul = p_mul_r; gain_div = p_div_r; end
      2'd1:    begin num = e_r;  gain_mul = i_mul_r; gain_div = i_div_r; end
      default: begin num = d2_r; gain_mul = d_mul_r; gain_div = d_div_r; end
    endcase
  end

  assign mag     = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
  assign div_eff = (gain_div == '0) ? GAIN_W'(1) : gain_div;

  // Divider request: product plus half the divisor
  assign div_req.start    = (state_r == ST_START);
  assign div_req.dividend = DIVIDEND_W'(prod_r) + DIVIDEND_W'(div_eff >> 1);
  assign div_req.divisor  = div_eff;

  ipid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quo_ext = neg_r ? -$signed(ACC_W'(div_rsp.quotient))
                         : $signed(ACC_W'(div_rsp.quotient));

  // Clamp: raise to floor, then lower to ceiling
  assign lo_ext = ACC_W'(floor_r);
  assign hi_ext = ACC_W'(ceiling_r);
  assign t_lo   = (acc_r < lo_ext) ? lo_ext : acc_r;
  assign t_hi   = (t_lo > hi_ext) ? hi_ext : t_lo;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_mul_r   <= '0;
      p_div_r   <= GAIN_W'(1);
      i_mul_r   <= '0;
      i_div_r   <= GAIN_W'(1);
      d_mul_r   <= '0;
      d_div_r   <= GAIN_W'(1);
      floor_r   <= {1'b1, {(DRIVE_W-1){1'b0}}};
      ceiling_r <= {1'b0, {(DRIVE_W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_MUL:   p_mul_r   <= cfg_wdata[GAIN_W-1:0];
        REG_P_DIV:   p_div_r   <= cfg_wdata[GAIN_W-1:0];
        REG_I_MUL:   i_mul_r   <= cfg_wdata[GAIN_W-1:0];
        REG_I_DIV:   i_div_r   <= cfg_wdata[GAIN_W-1:0];
        REG_D_MUL:   d_mul_r   <= cfg_wdata[GAIN_W-1:0];
        REG_D_DIV:   d_div_r   <= cfg_wdata[GAIN_W-1:0];
        REG_FLOOR:   floor_r   <= $signed(cfg_wdata[DRIVE_W-1:0]);
        REG_CEILING: ceiling_r <= $signed(cfg_wdata[DRIVE_W-1:0]);
        default:     ;
      endcase
    end
  end

  // Sequencer and error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_r      <= '0;
      e1_r        <= '0;
      e2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise the response flag when a result lands, drop it once taken
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_req.req_type == REQ_CLEAR) begin
              e1_r <= '0;
              e2_r <= '0;
            end else begin
              e1_r    <= err;
              e2_r    <= e1_r;
              term_r  <= '0;
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL:   state_r <= ST_START;
        ST_START: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            if (term_r == 2'd2) begin
              state_r <= ST_DONE;
            end else begin
              term_r  <= term_r + 2'd1;
              state_r <= ST_MUL;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      e_r   <= err_x;
      dp_r  <= err_x - DIFF_W'(e1_r);
      d2_r  <= err_x - (DIFF_W'(e1_r) <<< 1) + DIFF_W'(e2_r);
      acc_r <= '0;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(mag) * PROD_W'(gain_mul);
      neg_r  <= num[DIFF_W-1];
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      acc_r <= acc_r + quo_ext;
    end
    if (state_r == ST_DONE && out_free) begin
      drive_r   <= t_hi[DRIVE_W-1:0];
      clamped_r <= (t_hi != acc_r);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.drive_delta = drive_r;
  assign out_rsp.clamped     = clamped_r;

`ifndef ASSERT_OFF
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.req_type == REQ_CLEAR |=> e1_r == '0 && e2_r == '0)
    else $error("history not cleared");

  a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req.req_type == REQ_UPDATE |=> e2_r == $past(e1_r))
    else $error("history did not shift in order");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> term_r != 2'd3)
    else $error("term index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp.ready |=> $stable(drive_r) && $stable(clamped_r))
    else $error("pending response overwritten");
`endif

endmodule
